// ===== rtl/gpt_pkg.sv =====
// Shared types and constants for the grid point thinning block.
`default_nettype none
package gpt_pkg;
  localparam int CoordW = 20;
  localparam int CellW  = 20;
  localparam int IdxW   = 6;
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusZeroCell = 2'd1;
  localparam logic [1:0] StatusGridBig  = 2'd2;
  localparam logic [1:0] StatusOverflow = 2'd3;

  typedef struct packed {
    logic start_div;   // start a divide of the stored point at rd index
    logic first;       // this divide opens the bounding box pass
    logic bbox_upd;    // fold the quotients into the bounding box
    logic clr_map;     // clear one bitmap word
    logic map_rd;      // look up the cell of the current point
    logic map_wr;      // mark the cell of the current point
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic grid_big;
    logic cell_free;
  } stat_t;
endpackage
`default_nettype wire

// ===== rtl/gpt_ram.sv =====
// Generic single-port RAM with registered read.
`default_nettype none
module gpt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ===== rtl/gpt_div.sv =====
// Restoring divider: signed 20-bit dividend by unsigned 20-bit divisor, truncating.
`default_nettype none
module gpt_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic signed [gpt_pkg::CoordW-1:0] dividend,
  input  wire logic [gpt_pkg::CellW-1:0]      divisor,
  output logic                                done,
  output logic signed [gpt_pkg::CoordW:0]     quotient
);
  localparam int W = gpt_pkg::CoordW;
  logic [W-1:0] q_r, q_nxt;
  logic [W:0]   rem_r, rem_nxt;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt, neg_r, neg_nxt, done_r, done_nxt;
  logic [W:0]   trial;
  logic [W:0]   shifted;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    neg_nxt = neg_r; done_nxt = 1'b0;
    shifted = {rem_r[W-1:0], q_r[W-1]};
    trial = shifted - {1'b0, divisor};
    if (start) begin
      neg_nxt = dividend[W-1];
      q_nxt = dividend[W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt = '0; cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial; q_nxt = {q_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted; q_nxt = {q_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(W - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign quotient = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
endmodule
`default_nettype wire

// ===== rtl/gpt_datapath.sv =====
// Datapath: point stores, divider, bounding box, occupancy bitmap.
`default_nettype none
module gpt_datapath #(
  parameter int MaxPoints = 64,
  parameter int GridCells = 4096
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               st_we,
  input  wire logic [$clog2(MaxPoints)-1:0]       st_addr,
  input  wire logic signed [gpt_pkg::CoordW-1:0]  wr_x,
  input  wire logic signed [gpt_pkg::CoordW-1:0]  wr_y,
  input  wire logic [gpt_pkg::CellW-1:0]          cell_size,
  input  wire logic [$clog2(GridCells)-1:0]       clr_addr,
  input  wire gpt_pkg::cmd_t                      cmd,
  output gpt_pkg::stat_t                          stat,
  output logic signed [gpt_pkg::CoordW-1:0]       rd_x,
  output logic signed [gpt_pkg::CoordW-1:0]       rd_y
);
  localparam int AW = $clog2(GridCells);
  localparam int QW = gpt_pkg::CoordW + 1;
  logic dx_done, dy_done;
  logic signed [QW-1:0] qx, qy;
  logic signed [QW-1:0] minx_r, maxx_r, miny_r, maxy_r;
  logic [QW:0] wx, wy;
  logic [2*QW+1:0] area;
  logic [QW:0] ox, oy;
  logic [2*QW+1:0] grid_idx;
  logic [2*QW+1:0] grid_idx_r;
  logic map_q, map_we;
  logic [AW-1:0] map_addr;

  gpt_ram #(.Width(gpt_pkg::CoordW), .Depth(MaxPoints)) u_xs (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(wr_x), .rdata(rd_x));
  gpt_ram #(.Width(gpt_pkg::CoordW), .Depth(MaxPoints)) u_ys (
    .clk(clk), .we(st_we), .addr(st_addr), .wdata(wr_y), .rdata(rd_y));

  gpt_div u_dx (.clk(clk), .rst_n(rst_n), .start(cmd.start_div), .dividend(rd_x),
    .divisor(cell_size), .done(dx_done), .quotient(qx));
  gpt_div u_dy (.clk(clk), .rst_n(rst_n), .start(cmd.start_div), .dividend(rd_y),
    .divisor(cell_size), .done(dy_done), .quotient(qy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      minx_r <= '0; maxx_r <= '0; miny_r <= '0; maxy_r <= '0;
    end else if (cmd.bbox_upd) begin
      if (cmd.first || qx < minx_r) minx_r <= qx;
      if (cmd.first || qx > maxx_r) maxx_r <= qx;
      if (cmd.first || qy < miny_r) miny_r <= qy;
      if (cmd.first || qy > maxy_r) maxy_r <= qy;
    end
  end

  assign wx = QW'(maxx_r - minx_r) + 1'b1;
  assign wy = QW'(maxy_r - miny_r) + 1'b1;
  assign area = wx * wy;
  assign ox = {1'b0, QW'(qx - minx_r)};
  assign oy = {1'b0, QW'(qy - miny_r)};
  assign grid_idx = (2*QW+2)'(ox) + oy * wx;

  // The bitmap address stays on the held cell after the lookup, so the read
  // data remains valid for as long as the decision waits on the output.
  always_ff @(posedge clk) begin
    if (cmd.map_rd) grid_idx_r <= grid_idx;
  end

  assign map_we = cmd.clr_map | cmd.map_wr;
  assign map_addr = cmd.clr_map ? clr_addr :
                    (cmd.map_rd ? grid_idx[AW-1:0] : grid_idx_r[AW-1:0]);

  gpt_ram #(.Width(1), .Depth(GridCells)) u_map (
    .clk(clk), .we(map_we), .addr(map_addr), .wdata(cmd.map_wr), .rdata(map_q));

  assign stat.div_done = dx_done & dy_done;
  assign stat.grid_big = area > (2*QW+2)'(GridCells);
  assign stat.cell_free = !map_q & (grid_idx_r < (2*QW+2)'(GridCells));
endmodule
`default_nettype wire

// ===== rtl/gpt_ctrl.sv =====
// Controller state machine sequencing collection, both passes and emission.
`default_nettype none
module gpt_ctrl #(
  parameter int MaxPoints = 64,
  parameter int GridCells = 4096
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             in_last,
  input  wire logic [gpt_pkg::CellW-1:0]        cell_size,
  output logic                                  st_we,
  output logic [$clog2(MaxPoints)-1:0]          st_addr,
  output logic [$clog2(GridCells)-1:0]          clr_addr,
  output gpt_pkg::cmd_t                         cmd,
  input  wire gpt_pkg::stat_t                   stat,
  output logic                                  emit,
  output logic [gpt_pkg::IdxW-1:0]              emit_idx,
  output logic [1:0]                            emit_status,
  output logic                                  emit_err,
  output logic                                  emit_last,
  input  wire logic                             out_busy
);
  localparam int PW = $clog2(MaxPoints);
  localparam int CW = $clog2(MaxPoints + 1);
  localparam int AW = $clog2(GridCells);
  localparam logic [3:0] S_COLLECT = 4'd0, S_CHECK = 4'd1, S_RD1 = 4'd2,
    S_DIV1 = 4'd3, S_AREA = 4'd4, S_CLEAR = 4'd5, S_RD2 = 4'd6, S_DIV2 = 4'd7,
    S_LOOK = 4'd8, S_DEC = 4'd9, S_EMIT = 4'd10, S_ERR = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [PW-1:0] i_r, i_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic ovf_r, ovf_nxt, pend_r, pend_nxt;
  logic [PW-1:0] pidx_r, pidx_nxt;
  logic [1:0] err_r, err_nxt;
  logic accept, is_lastpt;

  assign accept = in_valid & in_ready;
  assign in_ready = (state_r == S_COLLECT);
  assign st_we = accept & (cnt_r < CW'(MaxPoints));
  // The store read is registered, so it is addressed with the next point index.
  assign st_addr = accept ? cnt_r[PW-1:0] : i_nxt;
  assign clr_addr = clr_r;
  assign is_lastpt = (CW'(i_r) + 1'b1) == cnt_r;

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; i_nxt = i_r; clr_nxt = clr_r;
    ovf_nxt = ovf_r; pend_nxt = pend_r; pidx_nxt = pidx_r; err_nxt = err_r;
    cmd = '0; emit = 1'b0; emit_idx = '0; emit_status = gpt_pkg::StatusOk;
    emit_err = 1'b0; emit_last = 1'b0;
    unique case (state_r)
      S_COLLECT: if (accept) begin
        if (cnt_r < CW'(MaxPoints)) cnt_nxt = cnt_r + 1'b1;
        else ovf_nxt = 1'b1;
        if (in_last) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        i_nxt = '0; pend_nxt = 1'b0;
        if (cell_size == '0) begin
          err_nxt = gpt_pkg::StatusZeroCell; state_nxt = S_ERR;
        end else if (ovf_r) begin
          err_nxt = gpt_pkg::StatusOverflow; state_nxt = S_ERR;
        end else state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.start_div = 1'b1; state_nxt = S_DIV1;
      end
      S_DIV1: if (stat.div_done) begin
        cmd.bbox_upd = 1'b1; cmd.first = (i_r == '0);
        if (is_lastpt) state_nxt = S_AREA;
        else begin
          i_nxt = i_r + 1'b1; state_nxt = S_RD1;
        end
      end
      S_AREA: begin
        clr_nxt = '0; i_nxt = '0;
        if (stat.grid_big) begin
          err_nxt = gpt_pkg::StatusGridBig; state_nxt = S_ERR;
        end else state_nxt = S_CLEAR;
      end
      S_CLEAR: begin
        cmd.clr_map = 1'b1; clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(GridCells - 1)) state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.start_div = 1'b1; state_nxt = S_DIV2;
      end
      S_DIV2: if (stat.div_done) begin
        cmd.map_rd = 1'b1; state_nxt = S_LOOK;
      end
      S_LOOK: state_nxt = S_DEC;
      S_DEC: begin
        if (stat.cell_free) cmd.map_wr = 1'b1;
        state_nxt = S_EMIT;
        if (stat.cell_free && pend_r) begin
          // A newer kept point exists, so the pending one is not last.
          if (out_busy) state_nxt = S_DEC;
          else begin
            emit = 1'b1; emit_idx = gpt_pkg::IdxW'(pidx_r);
          end
        end
        if (stat.cell_free && !(pend_r && out_busy)) begin
          pend_nxt = 1'b1; pidx_nxt = i_r;
        end
        if (state_nxt == S_DEC) cmd.map_wr = 1'b0;
      end
      S_EMIT: begin
        if (!is_lastpt) begin
          i_nxt = i_r + 1'b1; state_nxt = S_RD2;
        end else if (!out_busy) begin
          emit = pend_r; emit_idx = gpt_pkg::IdxW'(pidx_r); emit_last = 1'b1;
          cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_COLLECT;
        end
      end
      S_ERR: if (!out_busy) begin
        emit = 1'b1; emit_err = 1'b1; emit_status = err_r; emit_last = 1'b1;
        cnt_nxt = '0; ovf_nxt = 1'b0; state_nxt = S_COLLECT;
      end
      default: state_nxt = S_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_COLLECT; cnt_r <= '0; ovf_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; pend_r <= pend_nxt;
    end
    i_r <= i_nxt; clr_r <= clr_nxt; pidx_r <= pidx_nxt; err_r <= err_nxt;
  end
endmodule
`default_nettype wire

// ===== rtl/grid_point_thinning_2d_top.sv =====
// Grid point thinning top level: collects a set, keeps first point per cell.
// Collection takes one word per cycle; the input stays closed while a set is processed.
// After the last point the set goes through a bounding box pass, the bitmap clear and a
// keep pass; a zero cell width or an overflow is reported before the passes, and a grid
// that is too big is reported after the bounding box pass.
// Synchronous active-low reset clears control; output stalls hold the keep pass.
`default_nettype none
module grid_point_thinning_2d_top #(
  parameter int MAX_POINTS = 64,
  parameter int GRID_CELLS = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [19:0]                in_point_x,
  input  wire logic signed [19:0]                in_point_y,
  input  wire logic                              in_last_point,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [5:0]                             out_kept_index,
  output logic signed [19:0]                     out_kept_x,
  output logic signed [19:0]                     out_kept_y,
  output logic [1:0]                             out_status,
  output logic                                   out_last_result,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [19:0]                       cfg_cell_size
);
  localparam int PW = $clog2(MAX_POINTS);
  logic [19:0] cell_r;
  logic st_we;
  logic [PW-1:0] st_addr;
  logic [$clog2(GRID_CELLS)-1:0] clr_addr;
  gpt_pkg::cmd_t cmd;
  gpt_pkg::stat_t stat;
  logic signed [19:0] rd_x, rd_y;
  logic emit, emit_err, emit_last;
  logic [5:0] emit_idx;
  logic [1:0] emit_status;
  logic busy;
  // Coordinates of a kept point are held until it is known whether it is the last one.
  logic signed [19:0] px_r, py_r;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) cell_r <= 20'd256;
    else if (cfg_valid) cell_r <= cfg_cell_size;
  end

  gpt_ctrl #(.MaxPoints(MAX_POINTS), .GridCells(GRID_CELLS)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .in_last(in_last_point), .cell_size(cell_r), .st_we(st_we), .st_addr(st_addr),
    .clr_addr(clr_addr), .cmd(cmd), .stat(stat), .emit(emit), .emit_idx(emit_idx),
    .emit_status(emit_status), .emit_err(emit_err), .emit_last(emit_last),
    .out_busy(busy));

  gpt_datapath #(.MaxPoints(MAX_POINTS), .GridCells(GRID_CELLS)) u_dp (
    .clk(clk), .rst_n(rst_n), .st_we(st_we), .st_addr(st_addr),
    .wr_x(in_point_x), .wr_y(in_point_y), .cell_size(cell_r), .clr_addr(clr_addr),
    .cmd(cmd), .stat(stat), .rd_x(rd_x), .rd_y(rd_y));

  // The store read data still shows the current point when its cell is marked.
  always_ff @(posedge clk) begin
    if (cmd.map_wr) begin
      px_r <= rd_x; py_r <= rd_y;
    end
  end

  assign busy = out_valid & !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else if (emit) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (emit) begin
      out_kept_index  <= emit_idx;
      out_kept_x      <= emit_err ? 20'sd0 : px_r;
      out_kept_y      <= emit_err ? 20'sd0 : py_r;
      out_status      <= emit_status;
      out_last_result <= emit_last;
    end
  end
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Testbench for the grid point thinning block: directed table, then random sets.
module tb;

  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic               lastp;
  } point_t;

  typedef struct {
    logic [5:0]         idx;
    logic signed [19:0] kx;
    logic signed [19:0] ky;
    logic [1:0]         st;
    logic               lastr;
  } kept_t;

  // One row of the directed table. When has_exp is set, the row ends a set
  // and the predictor's last queued status is checked against the hand-typed exp_st.
  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic               lastp;
    logic               has_exp;
    logic [1:0]         exp_st;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [19:0] in_point_x = '0;
  logic signed [19:0] in_point_y = '0;
  logic in_last_point = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [5:0] out_kept_index;
  logic signed [19:0] out_kept_x;
  logic signed [19:0] out_kept_y;
  logic [1:0] out_status;
  logic out_last_result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [19:0] cfg_cell_size = '0;

  grid_point_thinning_2d_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kept_index(out_kept_index), .out_kept_x(out_kept_x), .out_kept_y(out_kept_y),
    .out_status(out_status), .out_last_result(out_last_result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_cell_size(cfg_cell_size)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: our own copy of the set being collected and the register.
  logic [19:0] cell_width = 20'd256;
  logic signed [19:0] set_x [64];
  logic signed [19:0] set_y [64];
  int unsigned set_len = 0;
  bit set_over = 0;
  kept_t kept_q[$];
  int errors = 0;
  bit hold_off = 0;   // receiver holds off for a long stretch while set
  bit recv_idle = 0;  // per-word random stall of the receiver

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Folds one point into the set and, on the final point, queues the result words.
  task automatic thin_predict(input point_t p);
    int signed cx, cy, mnx, mxx, mny, mxy, cs;
    longint wx, wy, slot;
    bit occ [4096];
    kept_t k, outs[$];
    if (set_len < 64) begin
      set_x[set_len] = p.px;
      set_y[set_len] = p.py;
      set_len++;
    end else begin
      set_over = 1;
    end
    if (!p.lastp) return;
    k = '{idx: '0, kx: '0, ky: '0, st: gpt_pkg::StatusOk, lastr: 1'b1};
    if (cell_width == 0) begin
      k.st = gpt_pkg::StatusZeroCell;
      kept_q = {kept_q, k};
    end else if (set_over) begin
      k.st = gpt_pkg::StatusOverflow;
      kept_q = {kept_q, k};
    end else begin
      cs = int'(cell_width);
      mnx = 0; mxx = 0; mny = 0; mxy = 0;
      for (int i = 0; i < set_len; i++) begin
        // Division of signed ints truncates toward zero, as the block does.
        cx = int'(set_x[i]) / cs;
        cy = int'(set_y[i]) / cs;
        if (i == 0 || cx < mnx) mnx = cx;
        if (i == 0 || cx > mxx) mxx = cx;
        if (i == 0 || cy < mny) mny = cy;
        if (i == 0 || cy > mxy) mxy = cy;
      end
      wx = longint'(mxx) - mnx + 1;
      wy = longint'(mxy) - mny + 1;
      if (wx * wy > 4096) begin
        k.st = gpt_pkg::StatusGridBig;
        kept_q = {kept_q, k};
      end else begin
        for (int i = 0; i < set_len; i++) begin
          slot = (longint'(int'(set_x[i]) / cs) - mnx) +
                 (longint'(int'(set_y[i]) / cs) - mny) * wx;
          if (slot < 4096 && !occ[slot]) begin
            occ[slot] = 1;
            k = '{idx: i[5:0], kx: set_x[i], ky: set_y[i], st: gpt_pkg::StatusOk,
                  lastr: 1'b0};
            outs = {outs, k};
          end
        end
        if (outs.size() > 0) outs[outs.size()-1].lastr = 1'b1;
        foreach (outs[j]) kept_q = {kept_q, outs[j]};
      end
    end
    set_len = 0;
    set_over = 0;
  endtask

  // Sends one word and waits for its acceptance; the predictor runs at acceptance.
  // Valid stays up after acceptance only when the next word follows with no gap;
  // drain_results takes it down before the sender goes quiet.
  task automatic send_point(input point_t p);
    int gap;
    gap = $urandom_range(0, 7);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= p.px;
    in_point_y <= p.py;
    in_last_point <= p.lastp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    thin_predict(p);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Register writes happen only with the block idle.
  task automatic write_cell(input logic [19:0] w);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_cell_size <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cell_width = w;
  endtask

  // Sends one random set; most points lie within the spread, some take full-range coordinates.
  task automatic random_set(input int len, input int spread);
    point_t p;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        p.px = 20'($urandom);
        p.py = 20'($urandom);
      end else begin
        p.px = 20'($signed($urandom_range(0, 2 * spread)) - spread);
        p.py = 20'($signed($urandom_range(0, 2 * spread)) - spread);
      end
      p.lastp = (i == len - 1);
      send_point(p);
    end
  endtask

  // Receiver: random stall per word, plus the long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          report("unexpected word", out_kept_index, 0);
        end else begin
          if (out_kept_index !== kept_q[0].idx)
            report("kept_index", out_kept_index, kept_q[0].idx);
          if (out_kept_x !== kept_q[0].kx) report("kept_x", out_kept_x, kept_q[0].kx);
          if (out_kept_y !== kept_q[0].ky) report("kept_y", out_kept_y, kept_q[0].ky);
          if (out_status !== kept_q[0].st) report("status", out_status, kept_q[0].st);
          if (out_last_result !== kept_q[0].lastr)
            report("last_result", out_last_result, kept_q[0].lastr);
          void'(kept_q.pop_front());
        end
      end
      out_ready <= !hold_off && !recv_idle;
    end
  end

  // Draws a random stall per word, with stall-free stretches.
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (n != 0) begin
          recv_idle <= 1'b1;
          repeat (n) @(posedge clk);
          recv_idle <= 1'b0;
        end
      end
    end
  end

  row_t rows[$];

  initial begin
    point_t p;
    rows = '{
      // Single point: always kept, alone in its set.
      '{20'sd0, 20'sd0, 1'b1, 1'b0, gpt_pkg::StatusOk},
      // Extremes of both coordinates in one set: grid far too big at width 1.0.
      '{20'sh7FFFF, 20'sh7FFFF, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{20'sh80000, 20'sh80000, 1'b1, 1'b1, gpt_pkg::StatusGridBig},
      // Duplicates and a near neighbor: first of each cell kept.
      '{20'sd300, 20'sd300, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{20'sd300, 20'sd300, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{20'sd310, 20'sd500, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{-20'sd300, 20'sd600, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{-20'sd100, 20'sd100, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{20'sd100, -20'sd100, 1'b1, 1'b0, gpt_pkg::StatusOk},
      // Coordinates straddling zero share cell zero by truncation.
      '{-20'sd255, -20'sd1, 1'b0, 1'b0, gpt_pkg::StatusOk},
      '{20'sd255, 20'sd1, 1'b1, 1'b0, gpt_pkg::StatusOk}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      p = '{px: rows[r].px, py: rows[r].py, lastp: rows[r].lastp};
      send_point(p);
      if (rows[r].has_exp) begin
        if (kept_q.size() == 0 || kept_q[$].st != rows[r].exp_st)
          report("directed status", kept_q.size() ? kept_q[$].st : 0, rows[r].exp_st);
      end
    end

    // Zero cell width: error on the set.
    write_cell(20'd0);
    send_point('{px: 20'sd5, py: 20'sd5, lastp: 1'b0});
    send_point('{px: 20'sd9, py: 20'sd9, lastp: 1'b1});
    // Widest cell: everything falls in one cell.
    write_cell(20'hFFFFF);
    random_set(6, 500000);
    // Too many points: 65 points in one set.
    write_cell(20'd4096);
    random_set(65, 4000);
    // Smallest nonzero width with tightly packed points.
    write_cell(20'd1);
    random_set(8, 20);

    // Long hold-off on the receiver while the sender keeps offering sets.
    write_cell(20'd256);
    hold_off <= 1'b1;
    fork
      begin
        repeat (12000) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        random_set(6, 2000);
        random_set(6, 2000);
      end
    join
    drain_results();

    // Random phases with a few settings.
    for (int ph = 0; ph < 4; ph++) begin
      write_cell(($urandom_range(0, 7) == 0) ? 20'd0 : 20'(1 << $urandom_range(4, 12))
                 + 20'($urandom_range(0, 99)));
      random_set($urandom_range(1, 8), $urandom_range(100, 20000));
    end

    drain_results();
    if (errors == 0)
      $display("grid_point_thinning_2d_top verification clean");
    else
      $display("grid_point_thinning_2d_top verification failed");
    $finish;
  end

  initial begin
    #12000000;
    $display("grid_point_thinning_2d_top verification failed");
    $finish;
  end
endmodule

// ===== grid_point_thinning_2d_top.f =====
rtl/gpt_pkg.sv
rtl/gpt_ram.sv
rtl/gpt_div.sv
rtl/gpt_datapath.sv
rtl/gpt_ctrl.sv
rtl/grid_point_thinning_2d_top.sv
test/tb.sv
